FILE: rtl/deq_pkg.sv
package deq_pkg;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 5;

	localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [2:0] KIND_POP_BACK   = 3'd3;
	localparam logic [2:0] KIND_DUMP       = 3'd4;

	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]               kind;
		logic signed [DATA_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] item_value;
		logic [COUNT_W-1:0]       count;
		logic                     last;
	} out_t;

endpackage

FILE: rtl/double_ended_queue_unit.sv
// Channel   Signals                          Payload
// -------   ------------------------------   ---------------------------------
// input     in_valid / in_ready / in_data    kind, value
// output    out_valid / out_ready / out_data status, item_value, count, last
//
// One request at a time. Push: result goes straight to the output register.
// Pop: one RAM read, then the result. Dump: one read, then one element per
// cycle unless the output stalls; next read issued while current is sent.
// A finished result sits in the output register while the next request is
// taken; a second result waits in a hold register and stops intake.
// Reset clears state, pointers, count and out_valid; the RAM is not cleared.
module double_ended_queue_unit #(
	parameter int CAPACITY = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  deq_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output deq_pkg::out_t  out_data
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int OW = deq_pkg::COUNT_W;

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_DUMP, ST_HOLD} state_t;

	state_t        state_q;
	logic [IW-1:0] front_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] idx_q;
	logic          more_q;
	deq_pkg::out_t hold_q;
	deq_pkg::out_t out_q;
	logic          out_valid_q;

	logic                       acc;
	logic                       slot_free;
	logic                       full;
	logic                       empty;
	logic                       is_push;
	logic                       is_pop;
	logic [IW-1:0]              front_dec;
	logic [IW-1:0]              front_inc;
	logic [IW:0]                nxt_off;
	logic                       dump_last;
	logic                       mem_we;
	logic [IW-1:0]              mem_waddr;
	logic                       mem_re;
	logic [IW-1:0]              mem_raddr;
	logic [deq_pkg::DATA_W-1:0] mem_rdata;
	logic [CW-1:0]              cnt_inc;
	logic [CW-1:0]              cnt_dec;
	deq_pkg::out_t              res;
	logic                       res_emit;

	function automatic logic [IW-1:0] ring(input logic [IW-1:0] a, input logic [IW-1:0] b);
		logic [IW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (IW+1)'(CAPACITY)) begin
			s = s - (IW+1)'(CAPACITY);
		end
		return s[IW-1:0];
	endfunction

	function automatic logic [OW-1:0] cnt5(input logic [CW-1:0] c);
		logic [CW+OW-1:0] e;
		e = {{OW{1'b0}}, c};
		return e[OW-1:0];
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign acc       = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign full      = (cnt_q == CW'(CAPACITY));
	assign empty     = (cnt_q == '0);
	assign is_push   = (in_data.kind == deq_pkg::KIND_PUSH_FRONT) ||
	                   (in_data.kind == deq_pkg::KIND_PUSH_BACK);
	assign is_pop    = (in_data.kind == deq_pkg::KIND_POP_FRONT) ||
	                   (in_data.kind == deq_pkg::KIND_POP_BACK) ||
	                   (in_data.kind == deq_pkg::KIND_DUMP);
	assign front_dec = (front_q == '0) ? IW'(CAPACITY - 1) : front_q - 1'b1;
	assign front_inc = ring(front_q, IW'(1));
	assign cnt_inc   = cnt_q + 1'b1;
	assign cnt_dec   = cnt_q - 1'b1;
	assign nxt_off   = {1'b0, idx_q} + 1'b1;
	assign dump_last = (nxt_off == (IW+1)'(cnt_q));

	always_comb begin
		mem_we    = acc && is_push && !full;
		mem_waddr = (in_data.kind == deq_pkg::KIND_PUSH_FRONT) ? front_dec
		                                                       : ring(front_q, cnt_q[IW-1:0]);
		mem_re    = 1'b0;
		mem_raddr = front_q;
		if (acc && is_pop && !empty) begin
			mem_re = 1'b1;
			if (in_data.kind == deq_pkg::KIND_POP_BACK) begin
				mem_raddr = ring(front_q, cnt_dec[IW-1:0]);
			end
		end else if (state_q == ST_DUMP && !dump_last && slot_free) begin
			mem_re    = 1'b1;
			mem_raddr = ring(front_q, nxt_off[IW-1:0]);
		end else if (state_q == ST_HOLD && more_q && slot_free) begin
			mem_re    = 1'b1;
			mem_raddr = ring(front_q, idx_q);
		end
	end

	always_comb begin
		res      = '0;
		res_emit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				res.last = 1'b1;
				res.count = cnt5(cnt_q);
				if (acc && is_push) begin
					res_emit = 1'b1;
					if (full) begin
						res.status = deq_pkg::STATUS_FULL;
					end else begin
						res.status = deq_pkg::STATUS_DONE;
						res.count  = cnt5(cnt_inc);
					end
				end else if (acc && is_pop && empty) begin
					res_emit   = 1'b1;
					res.status = deq_pkg::STATUS_EMPTY;
				end
			end
			ST_READ: begin
				res_emit       = 1'b1;
				res.status     = deq_pkg::STATUS_DONE;
				res.item_value = mem_rdata;
				res.count      = cnt5(cnt_q);
				res.last       = 1'b1;
			end
			ST_DUMP: begin
				res_emit       = 1'b1;
				res.status     = deq_pkg::STATUS_DONE;
				res.item_value = mem_rdata;
				res.count      = cnt5(cnt_q);
				res.last       = dump_last;
			end
			ST_HOLD: begin
				res = hold_q;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			front_q     <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			more_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((res_emit || state_q == ST_HOLD) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (res_emit) begin
				if (slot_free) begin
					out_q <= res;
				end else begin
					hold_q <= res;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (in_data.kind)
							deq_pkg::KIND_PUSH_FRONT,
							deq_pkg::KIND_PUSH_BACK: begin
								if (!full) begin
									cnt_q <= cnt_inc;
									if (in_data.kind == deq_pkg::KIND_PUSH_FRONT) begin
										front_q <= front_dec;
									end
								end
								more_q <= 1'b0;
								if (!slot_free) begin
									state_q <= ST_HOLD;
								end
							end
							deq_pkg::KIND_POP_FRONT,
							deq_pkg::KIND_POP_BACK: begin
								more_q <= 1'b0;
								if (empty) begin
									if (!slot_free) begin
										state_q <= ST_HOLD;
									end
								end else begin
									cnt_q   <= cnt_dec;
									state_q <= ST_READ;
									if (in_data.kind == deq_pkg::KIND_POP_FRONT) begin
										front_q <= front_inc;
									end
								end
							end
							deq_pkg::KIND_DUMP: begin
								more_q <= 1'b0;
								idx_q  <= '0;
								if (empty) begin
									if (!slot_free) begin
										state_q <= ST_HOLD;
									end
								end else begin
									state_q <= ST_DUMP;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					more_q  <= 1'b0;
					state_q <= slot_free ? ST_IDLE : ST_HOLD;
				end
				ST_DUMP: begin
					if (dump_last) begin
						more_q  <= 1'b0;
						state_q <= slot_free ? ST_IDLE : ST_HOLD;
					end else begin
						idx_q  <= nxt_off[IW-1:0];
						more_q <= 1'b1;
						if (!slot_free) begin
							state_q <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (slot_free) begin
						out_q   <= hold_q;
						state_q <= more_q ? ST_DUMP : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	deq_ram #(
		.DEPTH(CAPACITY),
		.AW(IW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(in_data.value),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !mem_re)
		else $error("RAM write and read in the same cycle");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> cnt_q == $past(cnt_inc))
		else $error("accepted push did not raise the count");

	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD) |-> (!in_ready && out_valid_q))
		else $error("hold state without a pending output");

endmodule

FILE: rtl/deq_ram.sv
module deq_ram #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [deq_pkg::DATA_W-1:0]  wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [deq_pkg::DATA_W-1:0]  rdata
);

	logic [deq_pkg::DATA_W-1:0] mem_q [DEPTH];
	logic [deq_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
